// ----- sv/plucker_line_rigid_transform_unit_defines.svh -----
// -----------------------------------------------------------------------------
// plucker line rigid transform unit - assertion macros
// shared property forms for the block's checker
// -----------------------------------------------------------------------------
`ifndef PLUCKER_LINE_RIGID_TRANSFORM_UNIT_DEFINES_SVH
`define PLUCKER_LINE_RIGID_TRANSFORM_UNIT_DEFINES_SVH

// same-cycle implication, masked while in reset
`define PLRT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while in reset
`define PLRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define PLRT_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/plrt_pkg.sv -----
// -----------------------------------------------------------------------------
// plrt_pkg
// types, widths and helpers for the plucker line rigid transform unit
// -----------------------------------------------------------------------------
package plrt_pkg;

    // configuration register file
    localparam int REG_W     = 48;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW0    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW1    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW2    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSLATION = 2'd3;

    // identity transform after reset
    localparam logic [REG_W-1:0] ROT_ROW0_RST    = 48'h0000_0000_4000;
    localparam logic [REG_W-1:0] ROT_ROW1_RST    = 48'h0000_4000_0000;
    localparam logic [REG_W-1:0] ROT_ROW2_RST    = 48'h4000_0000_0000;
    localparam logic [REG_W-1:0] TRANSLATION_RST = 48'h0000_0000_0000;

    // opcodes
    localparam logic OP_FORWARD = 1'b0;
    localparam logic OP_INVERSE = 1'b1;

    // datapath widths
    localparam int LANE_W    = 16;
    localparam int PROD_W    = 32;   // 16x16 product
    localparam int SUM_W     = 33;   // sum of three products
    localparam int TV_W      = 19;   // effective translation, q11.8
    localparam int CR_W      = 52;   // cross product term, 36 fraction bits
    localparam int NM_W      = 53;   // new moment before rounding
    localparam int SAT_IN_W  = 25;   // rounded value ahead of clipping
    localparam int SPLIT_LO  = 17;   // low slice of the wide multiplicand

    localparam logic signed [NM_W-1:0]     NM_RND  = 53'sd134217728;
    localparam logic signed [SUM_W:0]      RV_RND  = 34'sd8192;
    localparam logic signed [SAT_IN_W-1:0] SAT_MAX = 25'sd32767;
    localparam logic signed [SAT_IN_W-1:0] SAT_MIN = -25'sd32768;

    typedef logic signed [LANE_W-1:0] t_lane;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic signed [TV_W-1:0]   t_tv;
    typedef logic signed [CR_W-1:0]   t_cr;

    // input request
    typedef struct packed {
        logic  opcode;
        t_lane moment_x;
        t_lane moment_y;
        t_lane moment_z;
        t_lane dir_x;
        t_lane dir_y;
        t_lane dir_z;
    } t_in_req;

    // output result
    typedef struct packed {
        t_lane out_moment_x;
        t_lane out_moment_y;
        t_lane out_moment_z;
        t_lane out_dir_x;
        t_lane out_dir_y;
        t_lane out_dir_z;
        logic  saturated;
    } t_out_res;

    // clipped value with its flag
    typedef struct packed {
        logic  clip;
        t_lane val;
    } t_sat_res;

    // register loads for the cross product unit
    typedef struct packed {
        logic load_pp;
        logic load_sum;
    } t_cross_en;

    // clip to the signed 16 bit range
    function automatic t_sat_res sat16(input logic signed [SAT_IN_W-1:0] x);
        t_sat_res r;
        if (x > SAT_MAX) begin
            r.clip = 1'b1;
            r.val  = 16'sh7fff;
        end else if (x < SAT_MIN) begin
            r.clip = 1'b1;
            r.val  = -16'sh8000;
        end else begin
            r.clip = 1'b0;
            r.val  = x[LANE_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- sv/plrt_cross.sv -----
// -----------------------------------------------------------------------------
// plrt_cross
// two-stage cross product t x (R v) with split wide multiplications
// -----------------------------------------------------------------------------
module plrt_cross (
    input  logic                  i_clk,
    input  plrt_pkg::t_cross_en   i_en,
    input  plrt_pkg::t_tv         i_tv [3],
    input  plrt_pkg::t_sum        i_rv [3],
    output plrt_pkg::t_cr         o_cr [3]
);

    localparam int LO_W = plrt_pkg::SPLIT_LO + 1;
    localparam int HI_W = plrt_pkg::SUM_W - plrt_pkg::SPLIT_LO;
    localparam int PLO_W = plrt_pkg::TV_W + LO_W;
    localparam int PHI_W = plrt_pkg::TV_W + HI_W;

    logic signed [PLO_W-1:0] r_pp_lo [6];
    logic signed [PHI_W-1:0] r_pp_hi [6];
    logic signed [PLO_W-1:0] n_pp_lo [6];
    logic signed [PHI_W-1:0] n_pp_hi [6];
    plrt_pkg::t_cr           r_cr    [3];
    plrt_pkg::t_cr           n_cr    [3];

    genvar c;
    generate
        for (c = 0; c < 3; c++) begin : g_comp
            localparam int A = (c + 1) % 3;
            localparam int B = (c + 2) % 3;

            logic signed [LO_W-1:0] lo_a, lo_b;
            logic signed [HI_W-1:0] hi_a, hi_b;

            // split each R v term into an unsigned low and a signed high slice
            always_comb begin
                lo_a = $signed({1'b0, i_rv[B][plrt_pkg::SPLIT_LO-1:0]});
                hi_a = i_rv[B][plrt_pkg::SUM_W-1:plrt_pkg::SPLIT_LO];
                lo_b = $signed({1'b0, i_rv[A][plrt_pkg::SPLIT_LO-1:0]});
                hi_b = i_rv[A][plrt_pkg::SUM_W-1:plrt_pkg::SPLIT_LO];
                n_pp_lo[2*c]     = PLO_W'(i_tv[A]) * PLO_W'(lo_a);
                n_pp_hi[2*c]     = PHI_W'(i_tv[A]) * PHI_W'(hi_a);
                n_pp_lo[2*c + 1] = PLO_W'(i_tv[B]) * PLO_W'(lo_b);
                n_pp_hi[2*c + 1] = PHI_W'(i_tv[B]) * PHI_W'(hi_b);
            end

            // recombine partial products and take the difference
            always_comb begin
                n_cr[c] = ((plrt_pkg::CR_W'(r_pp_hi[2*c]) <<< plrt_pkg::SPLIT_LO)
                           + plrt_pkg::CR_W'(r_pp_lo[2*c]))
                        - ((plrt_pkg::CR_W'(r_pp_hi[2*c + 1]) <<< plrt_pkg::SPLIT_LO)
                           + plrt_pkg::CR_W'(r_pp_lo[2*c + 1]));
            end
        end
    endgenerate

    // partial product stage
    always_ff @(posedge i_clk) begin
        if (i_en.load_pp) begin
            r_pp_lo <= n_pp_lo;
            r_pp_hi <= n_pp_hi;
        end
    end

    // combine stage
    always_ff @(posedge i_clk) begin
        if (i_en.load_sum) begin
            r_cr <= n_cr;
        end
    end

    assign o_cr = r_cr;

endmodule

// ----- sv/plucker_line_rigid_transform_unit.sv -----
// -----------------------------------------------------------------------------
// plucker_line_rigid_transform_unit
// five register stages from request accept to result valid
// throughput: one line per cycle unless the output stalls; the 16x16 and split
// 19x33 cross product multiplies are each one stage, so a stage never repeats
// reset: synchronous active low; pipeline emptied, identity transform loaded
// -----------------------------------------------------------------------------
module plucker_line_rigid_transform_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [plrt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [plrt_pkg::REG_W-1:0]         i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  plrt_pkg::t_in_req                  i_in_req,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output plrt_pkg::t_out_res                 o_out_res
);

    // configuration registers
    logic [plrt_pkg::REG_W-1:0] r_rot [3];
    logic [plrt_pkg::REG_W-1:0] r_trans;

    // stage valids and advance chain
    logic [4:0] r_vld;
    logic [5:0] adv;

    // stage 0: products
    plrt_pkg::t_lane rm [3][3];
    plrt_pkg::t_lane mv [3];
    plrt_pkg::t_lane dv [3];
    plrt_pkg::t_lane tl [3];
    plrt_pkg::t_prod n_s0_pm [3][3];
    plrt_pkg::t_prod n_s0_pd [3][3];
    plrt_pkg::t_prod n_s0_pt [3][3];
    plrt_pkg::t_prod r_s0_pm [3][3];
    plrt_pkg::t_prod r_s0_pd [3][3];
    plrt_pkg::t_prod r_s0_pt [3][3];
    logic            r_s0_op;

    // stage 1: sums
    plrt_pkg::t_sum  n_s1_rn [3];
    plrt_pkg::t_sum  n_s1_rv [3];
    plrt_pkg::t_tv   n_s1_tv [3];
    plrt_pkg::t_sum  r_s1_rn [3];
    plrt_pkg::t_sum  r_s1_rv [3];
    plrt_pkg::t_tv   r_s1_tv [3];

    // stages 2 and 3: cross product alongside
    plrt_pkg::t_sat_res n_s2_dir [3];
    plrt_pkg::t_sat_res r_s2_dir [3];
    plrt_pkg::t_sat_res r_s3_dir [3];
    plrt_pkg::t_sum     r_s2_rn  [3];
    plrt_pkg::t_sum     r_s3_rn  [3];
    plrt_pkg::t_cr      cr       [3];
    plrt_pkg::t_cross_en cross_en;

    // stage 4: output
    plrt_pkg::t_sat_res  mom_sat [3];
    plrt_pkg::t_out_res  n_out_res;
    plrt_pkg::t_out_res  r_out_res;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot[0] <= plrt_pkg::ROT_ROW0_RST;
            r_rot[1] <= plrt_pkg::ROT_ROW1_RST;
            r_rot[2] <= plrt_pkg::ROT_ROW2_RST;
            r_trans  <= plrt_pkg::TRANSLATION_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                plrt_pkg::REG_ROT_ROW0:    r_rot[0] <= i_cfg_data;
                plrt_pkg::REG_ROT_ROW1:    r_rot[1] <= i_cfg_data;
                plrt_pkg::REG_ROT_ROW2:    r_rot[2] <= i_cfg_data;
                plrt_pkg::REG_TRANSLATION: r_trans  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or its successor moves on
    always_comb begin
        adv[5] = i_out_ready;
        for (int k = 4; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_in_ready = adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) r_vld[0] <= i_in_valid;
            for (int k = 1; k < 5; k++) begin
                if (adv[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // rotation select (transposed for inverse) and all 16x16 products
    always_comb begin
        mv[0] = i_in_req.moment_x;
        mv[1] = i_in_req.moment_y;
        mv[2] = i_in_req.moment_z;
        dv[0] = i_in_req.dir_x;
        dv[1] = i_in_req.dir_y;
        dv[2] = i_in_req.dir_z;
        for (int i = 0; i < 3; i++) begin
            tl[i] = r_trans[16*i +: 16];
            for (int j = 0; j < 3; j++) begin
                if (i_in_req.opcode == plrt_pkg::OP_INVERSE) begin
                    rm[i][j] = r_rot[j][16*i +: 16];
                end else begin
                    rm[i][j] = r_rot[i][16*j +: 16];
                end
            end
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_s0_pm[i][j] = plrt_pkg::PROD_W'(rm[i][j]) * plrt_pkg::PROD_W'(mv[j]);
                n_s0_pd[i][j] = plrt_pkg::PROD_W'(rm[i][j]) * plrt_pkg::PROD_W'(dv[j]);
                n_s0_pt[i][j] = plrt_pkg::PROD_W'(rm[i][j]) * plrt_pkg::PROD_W'(tl[j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_s0_pm <= n_s0_pm;
            r_s0_pd <= n_s0_pd;
            r_s0_pt <= n_s0_pt;
            r_s0_op <= i_in_req.opcode;
        end
    end

    // row sums and effective translation
    always_comb begin
        plrt_pkg::t_sum          st;
        logic signed [plrt_pkg::SUM_W:0] neg;
        for (int i = 0; i < 3; i++) begin
            n_s1_rn[i] = plrt_pkg::SUM_W'(r_s0_pm[i][0]) + plrt_pkg::SUM_W'(r_s0_pm[i][1])
                       + plrt_pkg::SUM_W'(r_s0_pm[i][2]);
            n_s1_rv[i] = plrt_pkg::SUM_W'(r_s0_pd[i][0]) + plrt_pkg::SUM_W'(r_s0_pd[i][1])
                       + plrt_pkg::SUM_W'(r_s0_pd[i][2]);
            st = plrt_pkg::SUM_W'(r_s0_pt[i][0]) + plrt_pkg::SUM_W'(r_s0_pt[i][1])
               + plrt_pkg::SUM_W'(r_s0_pt[i][2]);
            // -(R^T t) rounded to 8 fraction bits
            neg = -((plrt_pkg::SUM_W + 1)'(st)) + plrt_pkg::RV_RND;
            if (r_s0_op == plrt_pkg::OP_INVERSE) begin
                n_s1_tv[i] = neg[plrt_pkg::TV_W + 13:14];
            end else begin
                n_s1_tv[i] = plrt_pkg::TV_W'(plrt_pkg::t_lane'(r_trans[16*i +: 16]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_s1_rn <= n_s1_rn;
            r_s1_rv <= n_s1_rv;
            r_s1_tv <= n_s1_tv;
        end
    end

    // cross product over stages 2 and 3
    assign cross_en.load_pp  = adv[2];
    assign cross_en.load_sum = adv[3];

    plrt_cross u_cross (
        .i_clk (i_clk),
        .i_en  (cross_en),
        .i_tv  (r_s1_tv),
        .i_rv  (r_s1_rv),
        .o_cr  (cr)
    );

    // direction rounding and clipping
    always_comb begin
        logic signed [plrt_pkg::SUM_W:0]  rr;
        logic signed [plrt_pkg::SUM_W-14:0] q;
        for (int i = 0; i < 3; i++) begin
            rr = (plrt_pkg::SUM_W + 1)'(r_s1_rv[i]) + plrt_pkg::RV_RND;
            q  = rr[plrt_pkg::SUM_W:14];
            n_s2_dir[i] = plrt_pkg::sat16(plrt_pkg::SAT_IN_W'(q));
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r_s2_rn  <= r_s1_rn;
            r_s2_dir <= n_s2_dir;
        end
        if (adv[3]) begin
            r_s3_rn  <= r_s2_rn;
            r_s3_dir <= r_s2_dir;
        end
    end

    // new moment: R n scaled up plus cross term, rounded and clipped
    always_comb begin
        logic signed [plrt_pkg::NM_W-1:0] nm;
        for (int i = 0; i < 3; i++) begin
            nm = (plrt_pkg::NM_W'(r_s3_rn[i]) <<< 14) + plrt_pkg::NM_W'(cr[i])
               + plrt_pkg::NM_RND;
            mom_sat[i] = plrt_pkg::sat16(nm[plrt_pkg::NM_W-1:28]);
        end
        n_out_res.out_moment_x = mom_sat[0].val;
        n_out_res.out_moment_y = mom_sat[1].val;
        n_out_res.out_moment_z = mom_sat[2].val;
        n_out_res.out_dir_x    = r_s3_dir[0].val;
        n_out_res.out_dir_y    = r_s3_dir[1].val;
        n_out_res.out_dir_z    = r_s3_dir[2].val;
        n_out_res.saturated    = mom_sat[0].clip | mom_sat[1].clip | mom_sat[2].clip
                               | r_s3_dir[0].clip | r_s3_dir[1].clip | r_s3_dir[2].clip;
    end

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r_out_res <= n_out_res;
        end
    end

    assign o_out_valid = r_vld[4];
    assign o_out_res   = r_out_res;

endmodule

// ----- sv/plrt_checker.sv -----
// -----------------------------------------------------------------------------
// plrt_checker
// port-level checks on the transform unit's request and result channels
// -----------------------------------------------------------------------------
`include "plucker_line_rigid_transform_unit_defines.svh"

module plrt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input plrt_pkg::t_out_res o_out_res
);

    // a stalled result stays offered
    `PLRT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "result dropped while stalled")

    // a stalled result keeps its value
    `PLRT_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_out_res), "result changed while stalled")

    // requests are only refused when the pipe is full and the output is stalled
    `PLRT_ASSERT_NOW(a_ready_backpressure, i_clk, i_rst_n, !o_in_ready, o_out_valid && !i_out_ready, "request refused without back-pressure")

    // reset empties the pipe
    `PLRT_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_out_valid, "result valid after reset")

endmodule

bind plucker_line_rigid_transform_unit plrt_checker u_plrt_checker (.*);
